FILE: sv/auc_pkg.sv
// Package for the address user-info classifier.
// Transaction types, hint and scheme codes, fixed lengths. No dependencies.
package auc_pkg;

  localparam int MAX_TEXT_LEN_DEF = 45;
  localparam int HASH_LEN         = 40;
  localparam int MIN_TEXT_LEN     = 3;
  localparam int CNT_W            = 6;

  localparam logic [1:0] SCHEME_OTHER = 2'd0;
  localparam logic [1:0] SCHEME_SIP   = 2'd1;
  localparam logic [1:0] SCHEME_HASH  = 2'd2;

  localparam logic [2:0] HINT_SIP_OTHER = 3'd0;
  localparam logic [2:0] HINT_SIP_HOST  = 3'd1;
  localparam logic [2:0] HINT_ID_HASH   = 3'd2;
  localparam logic [2:0] HINT_ID_USER   = 3'd3;
  localparam logic [2:0] HINT_IP        = 3'd4;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       has_byte;
    logic       end_of_string;
    logic [1:0] scheme_kind;
    logic       has_at;
  } in_item_t;

  typedef struct packed {
    logic [2:0] hint;
    logic       is_ip;
    logic       is_hash;
  } out_item_t;

endpackage

FILE: sv/auc_if.sv
// Valid/ready channel interfaces for the classifier.
// Depends on auc_pkg for the transaction types.
interface auc_in_if;
  import auc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface auc_out_if;
  import auc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/address_userinfo_classifier.sv
// Address user-info classifier, top level: byte scan and end-of-string verdict.
// Depends on auc_pkg and the channel interfaces in auc_if.sv.
//
// channel   dir  payload                                            handshake
// in_ch     in   char_byte has_byte end_of_string scheme_kind has_at valid/ready
// out_ch    out  hint is_ip is_hash                                 valid/ready
//
// One transaction per cycle while the result register is empty or being drained; a verdict
// appears in the cycle after its end-of-string transaction is taken, from the result register.
// The input is taken whenever the result register is empty or being drained.
// rst_n (synchronous) clears the scan state and the result valid.
// A stalled output holds its result and stalls the input only while full.
module address_userinfo_classifier #(
  parameter int MAX_TEXT_LEN = auc_pkg::MAX_TEXT_LEN_DEF
) (
  input logic      clk,
  input logic      rst_n,
  auc_in_if.sink   in_ch,
  auc_out_if.source out_ch
);
  import auc_pkg::*;

  localparam int LEN_W = $clog2(MAX_TEXT_LEN + 2);
  localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_TEXT_LEN);
  localparam logic [LEN_W-1:0] LEN_TOP  = LEN_W'(MAX_TEXT_LEN + 1);
  localparam logic [LEN_W-1:0] LEN_MIN  = LEN_W'(MIN_TEXT_LEN);
  localparam logic [LEN_W-1:0] LEN_HASH = LEN_W'(HASH_LEN);
  localparam logic [CNT_W-1:0] CNT_TOP  = '1;

  logic [LEN_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] dot_r, dot_nxt, col_r, col_nxt, run_r, run_nxt;
  logic             nohex_r, nohex_nxt, hbrk_r, hbrk_nxt, fail_r, fail_nxt;
  logic             out_valid_r;
  out_item_t        out_data_r, res;

  logic [LEN_W-1:0] len_b;
  logic [CNT_W-1:0] dot_b, col_b, run_b;
  logic             nohex_b, hbrk_b, fail_b;
  logic             in_fire, ip_core, ip, hash;
  logic [7:0]       c;
  in_item_t         it;

  assign it       = in_ch.data;
  assign c        = it.char_byte;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire  = in_ch.valid && in_ch.ready;

  always_comb begin
    len_b   = len_r;
    dot_b   = dot_r;
    col_b   = col_r;
    run_b   = run_r;
    nohex_b = nohex_r;
    hbrk_b  = hbrk_r;
    fail_b  = fail_r;
    if (it.has_byte) begin
      len_b = (len_r < LEN_TOP) ? len_r + 1'b1 : LEN_TOP;
      if (!fail_r) begin
        if (c == 8'h2E) begin
          hbrk_b = 1'b1;
          run_b  = '0;
          dot_b  = (dot_r < CNT_TOP) ? dot_r + 1'b1 : CNT_TOP;
        end else if (c >= 8'h30 && c <= 8'h39) begin
          run_b = (run_r < CNT_TOP) ? run_r + 1'b1 : CNT_TOP;
          if (run_b > CNT_W'(3) && dot_r != '0) fail_b = 1'b1;
        end else if (c == 8'h3A) begin
          hbrk_b  = 1'b1;
          col_b   = (col_r < CNT_TOP) ? col_r + 1'b1 : CNT_TOP;
          nohex_b = 1'b0;
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
          nohex_b = 1'b0;
        end else begin
          hbrk_b = 1'b1;
          fail_b = 1'b1;
        end
      end
    end

    hash    = (len_b == LEN_HASH) && !hbrk_b;
    ip_core = (nohex_b && dot_b == CNT_W'(3) && run_b < CNT_W'(4)) !=
              (col_b > CNT_W'(1) && dot_b == '0);
    if (len_b < LEN_MIN || len_b > LEN_MAX) ip = 1'b0;
    else if (it.scheme_kind == SCHEME_HASH && len_b != LEN_HASH) ip = 1'b0;
    else if (fail_b) ip = 1'b0;
    else ip = ip_core;

    res.is_ip   = ip;
    res.is_hash = hash;
    if (ip) res.hint = HINT_IP;
    else if (hash) res.hint = HINT_ID_HASH;
    else if (it.scheme_kind == SCHEME_HASH) res.hint = HINT_ID_USER;
    else if (it.scheme_kind == SCHEME_SIP && it.has_at) res.hint = HINT_SIP_HOST;
    else res.hint = HINT_SIP_OTHER;

    if (it.end_of_string) begin
      len_nxt   = '0;
      dot_nxt   = '0;
      col_nxt   = '0;
      run_nxt   = '0;
      nohex_nxt = 1'b1;
      hbrk_nxt  = 1'b0;
      fail_nxt  = 1'b0;
    end else begin
      len_nxt   = len_b;
      dot_nxt   = dot_b;
      col_nxt   = col_b;
      run_nxt   = run_b;
      nohex_nxt = nohex_b;
      hbrk_nxt  = hbrk_b;
      fail_nxt  = fail_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      dot_r       <= '0;
      col_r       <= '0;
      run_r       <= '0;
      nohex_r     <= 1'b1;
      hbrk_r      <= 1'b0;
      fail_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        len_r   <= len_nxt;
        dot_r   <= dot_nxt;
        col_r   <= col_nxt;
        run_r   <= run_nxt;
        nohex_r <= nohex_nxt;
        hbrk_r  <= hbrk_nxt;
        fail_r  <= fail_nxt;
      end
      if (in_fire && it.end_of_string) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && it.end_of_string) out_data_r <= res;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  a_ip_hint: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.is_ip == (out_data_r.hint == HINT_IP)))
    else $error("is_ip and ip hint disagree");

  a_hash_hint: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.is_hash && !out_data_r.is_ip)
      |-> (out_data_r.hint == HINT_ID_HASH))
    else $error("hash result without hash hint");

  a_clear_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && it.end_of_string)
      |=> (len_r == '0 && !fail_r && !hbrk_r && nohex_r))
    else $error("scan state not cleared after end of string");

  a_len_sat: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_TOP)
    else $error("length count beyond saturation");

endmodule

FILE: test/auc_checker.sv
// Scoreboard for the address user-info classifier: predicts one verdict per
// end-of-string transaction and compares it with the result channel.
// Depends on auc_pkg and the channel interfaces in auc_if.sv.
module auc_checker #(
  parameter int MAX_TEXT_LEN = auc_pkg::MAX_TEXT_LEN_DEF
) (
  input  logic clk,
  input  logic rst_n,
  auc_in_if    in_ch,
  auc_out_if   out_ch,
  output int   mismatches,
  output int   verdicts_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import auc_pkg::*;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;

  logic [6:0] text_len;
  logic [5:0] dots;
  logic [5:0] colons;
  logic [5:0] digit_run;
  logic       hex_free;
  logic       hash_broken;
  logic       frozen;
  out_item_t  due_verdicts[$];
  int         errs = 0;

  function automatic logic [5:0] bump(input logic [5:0] v);
    return (v == 6'h3F) ? v : v + 6'd1;
  endfunction

  task automatic clear_scan();
    text_len    = '0;
    dots        = '0;
    colons      = '0;
    digit_run   = '0;
    hex_free    = 1'b1;
    hash_broken = 1'b0;
    frozen      = 1'b0;
  endtask

  task automatic scan_char(input logic [7:0] c);
    if (text_len <= MAX_TEXT_LEN) text_len = text_len + 7'd1;
    if (!frozen) begin
      if (c == CH_DOT) begin
        hash_broken = 1'b1;
        digit_run   = '0;
        dots        = bump(dots);
      end else if (c >= "0" && c <= "9") begin
        digit_run = bump(digit_run);
        if (digit_run > 3 && dots != 0) frozen = 1'b1;
      end else if (c == CH_COLON) begin
        hash_broken = 1'b1;
        colons      = bump(colons);
        hex_free    = 1'b0;
      end else if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
        hex_free = 1'b0;
      end else begin
        hash_broken = 1'b1;
        frozen      = 1'b1;
      end
    end
  endtask

  function automatic out_item_t classify_text(input logic [1:0] scheme, input logic at);
    out_item_t r;
    logic      ip;
    logic      hsh;
    hsh = (text_len == HASH_LEN) && !hash_broken;
    if (text_len < MIN_TEXT_LEN || text_len > MAX_TEXT_LEN) ip = 1'b0;
    else if (scheme == SCHEME_HASH && text_len != HASH_LEN) ip = 1'b0;
    else if (frozen) ip = 1'b0;
    else ip = (hex_free && dots == 3 && digit_run < 4) != (colons > 1 && dots == 0);
    if (ip) r.hint = HINT_IP;
    else if (hsh) r.hint = HINT_ID_HASH;
    else if (scheme == SCHEME_HASH) r.hint = HINT_ID_USER;
    else if (scheme == SCHEME_SIP && at) r.hint = HINT_SIP_HOST;
    else r.hint = HINT_SIP_OTHER;
    r.is_ip   = ip;
    r.is_hash = hsh;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    out_item_t got;
    out_item_t want;
    in_item_t  it;
    if (!rst_n) begin
      clear_scan();
      due_verdicts.delete();
    end else begin
      // drain side first: a verdict never leaves in the cycle its text ends
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (due_verdicts.size() == 0) begin
          errs++;
          $display("%0t: unexpected verdict hint %0d ip %0b hash %0b, expected none",
                   $time, got.hint, got.is_ip, got.is_hash);
        end else begin
          want = due_verdicts.pop_front();
          if (got !== want) begin
            errs++;
            $display("%0t: expected hint %0d ip %0b hash %0b, got hint %0d ip %0b hash %0b",
                     $time, want.hint, want.is_ip, want.is_hash,
                     got.hint, got.is_ip, got.is_hash);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        it = in_ch.data;
        if (it.has_byte) scan_char(it.char_byte);
        if (it.end_of_string) begin
          due_verdicts.push_back(classify_text(it.scheme_kind, it.has_at));
          clear_scan();
        end
      end
    end
    mismatches   <= errs;
    verdicts_due <= due_verdicts.size();
  end

endmodule

FILE: test/tb_address_userinfo_classifier.sv
// Testbench top for the address user-info classifier: clock, reset, text
// stimulus with random idling on both channels, watchdog and verdict.
// Depends on auc_pkg, auc_if.sv, auc_checker.sv and the block itself.
module tb_address_userinfo_classifier;
  timeunit 1ns;
  timeprecision 1ps;
  import auc_pkg::*;

  localparam logic [1:0] SCHEME_UNUSED = 2'd3;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam int         STALL_LIMIT   = 2000;

  typedef logic [7:0] text_q_t[$];
  typedef enum int {K_IPV4, K_IPV6, K_HASH, K_USER, K_NOISE, K_LONG} text_kind_t;

  logic clk = 1'b0;
  logic rst_n;
  logic calm;
  int   mismatches;
  int   verdicts_due;
  int   items_sent;
  int   quiet_cycles = 0;

  auc_in_if  in_ch ();
  auc_out_if out_ch ();

  address_userinfo_classifier dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  auc_checker verdict_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .mismatches   (mismatches),
    .verdicts_due (verdicts_due)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 21);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [7:0] digit_char();
    return 8'h30 + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(15);
    if (v < 10) return 8'h30 + 8'(v);
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(v - 10);
  endfunction

  function automatic text_q_t bytes_of(input string s);
    text_q_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  function automatic text_q_t make_text(input text_kind_t kind);
    text_q_t t;
    text_q_t tail;
    int      n;
    int      k;
    case (kind)
      K_IPV4: begin
        n = ($urandom_range(7) == 0) ? $urandom_range(2, 5) : 4;
        for (int o = 0; o < n; o++) begin
          if (o > 0) t.push_back(CH_DOT);
          k = ($urandom_range(7) == 0) ? 4 : $urandom_range(1, 3);
          repeat (k) t.push_back(digit_char());
        end
      end
      K_IPV6: begin
        n = $urandom_range(3, 8);
        for (int g = 0; g < n; g++) begin
          if (g > 0) t.push_back(CH_COLON);
          repeat ($urandom_range(4)) t.push_back(hex_char());
        end
        if ($urandom_range(5) == 0) begin
          tail = make_text(K_IPV4);
          t.push_back(CH_COLON);
          foreach (tail[i]) t.push_back(tail[i]);
        end
      end
      K_HASH: begin
        n = ($urandom_range(5) == 0) ? ($urandom_range(1) ? 39 : 41) : HASH_LEN;
        repeat (n) t.push_back(hex_char());
        if ($urandom_range(7) == 0) begin
          k = $urandom_range(2);
          t[$urandom_range(n - 1)] = (k == 0) ? "g" : (k == 1) ? CH_DOT : CH_COLON;
        end
      end
      K_USER: begin
        repeat ($urandom_range(1, 20)) begin
          k = $urandom_range(9);
          if (k < 6) t.push_back(8'h61 + 8'($urandom_range(25)));
          else if (k < 8) t.push_back(digit_char());
          else t.push_back(k == 8 ? "_" : "-");
        end
      end
      K_NOISE: begin
        repeat ($urandom_range(12)) t.push_back(8'($urandom_range(255)));
      end
      default: begin
        repeat ($urandom_range(41, 52)) begin
          k = $urandom_range(5);
          t.push_back(k == 0 ? CH_DOT : k < 3 ? digit_char() : hex_char());
        end
      end
    endcase
    return t;
  endfunction

  task automatic put_item(input in_item_t it);
    while (!calm && $urandom_range(99) < 21) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // ends the text either on its last byte or on a separate byteless transaction
  task automatic send_text(input text_q_t t, input logic [1:0] scheme, input logic at);
    in_item_t it;
    bit       tail;
    tail = (t.size() == 0) || ($urandom_range(5) == 0);
    foreach (t[i]) begin
      if ($urandom_range(9) == 0) begin
        it = in_item_t'($urandom);
        it.has_byte      = 1'b0;
        it.end_of_string = 1'b0;
        put_item(it);
        items_sent++;
      end
      it = in_item_t'($urandom);
      it.char_byte     = t[i];
      it.has_byte      = 1'b1;
      it.end_of_string = (i == t.size() - 1) && !tail;
      if (it.end_of_string) begin
        it.scheme_kind = scheme;
        it.has_at      = at;
      end
      put_item(it);
      items_sent++;
    end
    if (tail) begin
      it = in_item_t'($urandom);
      it.has_byte      = 1'b0;
      it.end_of_string = 1'b1;
      it.scheme_kind   = scheme;
      it.has_at        = at;
      put_item(it);
      items_sent++;
    end
  endtask

  initial begin
    text_q_t    junk;
    text_q_t    t;
    text_kind_t kind;
    int         pick;
    int         texts;
    logic [1:0] scheme;
    rst_n        = 1'b0;
    calm         = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    items_sent   = 0;
    junk         = '{8'h00, 8'hFF, 8'h7A};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_text(bytes_of(""), SCHEME_UNUSED, 1'b1);
    send_text(bytes_of("::1"), SCHEME_SIP, 1'b1);
    send_text(bytes_of("1.2.3.4"), SCHEME_OTHER, 1'b1);
    send_text(bytes_of("aB"), SCHEME_SIP, 1'b1);
    send_text(junk, SCHEME_HASH, 1'b0);
    send_text(bytes_of("1.1.1.1234"), SCHEME_SIP, 1'b0);

    items_sent = 0;
    texts      = 0;
    while (items_sent < 450 || texts < 40) begin
      calm <= (texts >= 12 && texts < 20);
      pick = $urandom_range(99);
      kind = pick < 25 ? K_IPV4 : pick < 45 ? K_IPV6 : pick < 62 ? K_HASH :
             pick < 75 ? K_USER : pick < 87 ? K_NOISE : K_LONG;
      t = make_text(kind);
      scheme = (kind == K_HASH && $urandom_range(3) != 0) ? SCHEME_HASH
                                                          : 2'($urandom_range(3));
      send_text(t, scheme, 1'($urandom_range(1)));
      texts++;
    end
    in_ch.valid <= 1'b0;

    while (verdicts_due != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
